// File: rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and month table for the seconds to calendar block.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int TS_W    = 32;
	localparam int YEAR_W  = 12;
	localparam int YOC_W   = 7;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	// width of the shared compare / subtract unit
	localparam int ALU_W   = TS_W;

	localparam logic [ALU_W-1:0] SECS_COMMON_YEAR = 32'd31536000;
	localparam logic [ALU_W-1:0] SECS_LEAP_YEAR   = 32'd31622400;
	localparam logic [ALU_W-1:0] SECS_TEN_DAYS    = 32'd864000;
	localparam logic [ALU_W-1:0] SECS_PER_DAY     = 32'd86400;
	localparam logic [ALU_W-1:0] SECS_TEN_HOURS   = 32'd36000;
	localparam logic [ALU_W-1:0] SECS_PER_HOUR    = 32'd3600;
	localparam logic [ALU_W-1:0] SECS_TEN_MINS    = 32'd600;
	localparam logic [ALU_W-1:0] SECS_PER_MIN     = 32'd60;

	localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd1970;
	localparam logic [YOC_W-1:0]   BASE_YOC    = 7'd70;
	localparam logic [1:0]         BASE_CENT   = 2'd3;   // 19 mod 4
	localparam logic [YOC_W-1:0]   LAST_YOC    = 7'd99;
	localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd11;  // december, zero based

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_YEARS  = 7'b0000010,
		ST_MONTHS = 7'b0000100,
		ST_DAYS   = 7'b0001000,
		ST_HOURS  = 7'b0010000,
		ST_MINS   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} esc_state_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [YOC_W-1:0]   year_of_century;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day_of_month;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} esc_result_t;

	typedef struct packed {
		logic idle;
		logic done;
	} esc_stat_t;

	// seconds in a month, month zero based
	function automatic logic [ALU_W-1:0] month_secs(input logic leap,
		input logic [MONTH_W-1:0] m);
		logic [ALU_W-1:0] s;
		case (m)
			4'd1:    s = leap ? 32'd2505600 : 32'd2419200;
			4'd3:    s = 32'd2592000;
			4'd5:    s = 32'd2592000;
			4'd8:    s = 32'd2592000;
			4'd10:   s = 32'd2592000;
			default: s = 32'd2678400;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/esc_if.sv
// ----------------------------------------------------------------------------
// esc_if
// Valid / ready channels for the timestamp input and calendar result.
// ----------------------------------------------------------------------------
interface esc_stamp_if;
	logic                       valid;
	logic                       ready;
	logic [esc_pkg::TS_W-1:0]   timestamp;

	modport source (output valid, output timestamp, input ready);
	modport sink (input valid, input timestamp, output ready);
endinterface

interface esc_cal_if;
	logic                         valid;
	logic                         ready;
	logic [esc_pkg::YEAR_W-1:0]   year;
	logic [esc_pkg::YOC_W-1:0]    year_of_century;
	logic [esc_pkg::MONTH_W-1:0]  month;
	logic [esc_pkg::DAY_W-1:0]    day_of_month;
	logic [esc_pkg::HOUR_W-1:0]   hour;
	logic [esc_pkg::MIN_W-1:0]    minute;
	logic [esc_pkg::SEC_W-1:0]    second;

	modport source (output valid, output year, output year_of_century, output month,
		output day_of_month, output hour, output minute, output second, input ready);
	modport sink (input valid, input year, input year_of_century, input month,
		input day_of_month, input hour, input minute, input second, output ready);
endinterface

// File: rtl/core/esc_sub_unit.sv
// ----------------------------------------------------------------------------
// esc_sub_unit
// Shared compare and subtract: difference and a greater-or-equal flag.
// ----------------------------------------------------------------------------
module esc_sub_unit (
	input  logic [esc_pkg::ALU_W-1:0] a,
	input  logic [esc_pkg::ALU_W-1:0] b,
	output logic [esc_pkg::ALU_W-1:0] diff,
	output logic                      ge
);
	import esc_pkg::*;

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

// File: rtl/core/esc_calc.sv
// ----------------------------------------------------------------------------
// esc_calc
// Sequencer that walks years, months, days, hours and minutes off the
// seconds count on one shared compare / subtract unit.
// ----------------------------------------------------------------------------
module esc_calc (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [esc_pkg::TS_W-1:0] timestamp,
	input  logic                     take,
	output esc_pkg::esc_stat_t       stat,
	output esc_pkg::esc_result_t     result
);
	import esc_pkg::*;

	esc_state_t          state_q;
	logic                coarse_q;
	logic [ALU_W-1:0]    rem_q;
	logic [YEAR_W-1:0]   year_q;
	logic [YOC_W-1:0]    yoc_q;
	logic [1:0]          cent_q;
	logic [MONTH_W-1:0]  month_q;
	logic [DAY_W-1:0]    day_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MIN_W-1:0]    minute_q;

	logic [ALU_W-1:0]    alu_b;
	logic [ALU_W-1:0]    alu_diff;
	logic                alu_ge;
	logic                leap;

	// 4/100/400 rule on year mod 100 and century mod 4
	assign leap = ((yoc_q[1:0] == 2'd0) && (yoc_q != '0)) || ((yoc_q == '0) && (cent_q == 2'd0));

	// days, hours and minutes go in steps of ten first, then in steps of one
	always_comb begin
		case (state_q)
			ST_YEARS: begin
				alu_b = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
			end
			ST_MONTHS: begin
				alu_b = month_secs(leap, month_q);
			end
			ST_DAYS: begin
				alu_b = coarse_q ? SECS_TEN_DAYS : SECS_PER_DAY;
			end
			ST_HOURS: begin
				alu_b = coarse_q ? SECS_TEN_HOURS : SECS_PER_HOUR;
			end
			ST_MINS: begin
				alu_b = coarse_q ? SECS_TEN_MINS : SECS_PER_MIN;
			end
			default: begin
				alu_b = '0;
			end
		endcase
	end

	esc_sub_unit u_sub (
		.a    (rem_q),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			coarse_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_YEARS;
					end
				end
				ST_YEARS: begin
					if (!alu_ge) begin
						state_q <= ST_MONTHS;
					end
				end
				ST_MONTHS: begin
					if ((month_q == LAST_MONTH) || !alu_ge) begin
						state_q <= ST_DAYS;
					end
				end
				ST_DAYS: begin
					if (!alu_ge) begin
						coarse_q <= ~coarse_q;
						if (!coarse_q) begin
							state_q <= ST_HOURS;
						end
					end
				end
				ST_HOURS: begin
					if (!alu_ge) begin
						coarse_q <= ~coarse_q;
						if (!coarse_q) begin
							state_q <= ST_MINS;
						end
					end
				end
				ST_MINS: begin
					if (!alu_ge) begin
						coarse_q <= ~coarse_q;
						if (!coarse_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q  <= ST_IDLE;
					coarse_q <= 1'b1;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q    <= timestamp;
				year_q   <= BASE_YEAR;
				yoc_q    <= BASE_YOC;
				cent_q   <= BASE_CENT;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
			end
			ST_YEARS: begin
				if (alu_ge) begin
					rem_q  <= alu_diff;
					year_q <= year_q + 12'd1;
					if (yoc_q == LAST_YOC) begin
						yoc_q  <= '0;
						cent_q <= cent_q + 2'd1;
					end else begin
						yoc_q <= yoc_q + 7'd1;
					end
				end
			end
			ST_MONTHS: begin
				if ((month_q != LAST_MONTH) && alu_ge) begin
					rem_q   <= alu_diff;
					month_q <= month_q + 4'd1;
				end
			end
			ST_DAYS: begin
				if (alu_ge) begin
					rem_q <= alu_diff;
					day_q <= day_q + (coarse_q ? 5'd10 : 5'd1);
				end
			end
			ST_HOURS: begin
				if (alu_ge) begin
					rem_q  <= alu_diff;
					hour_q <= hour_q + (coarse_q ? 5'd10 : 5'd1);
				end
			end
			ST_MINS: begin
				if (alu_ge) begin
					rem_q    <= alu_diff;
					minute_q <= minute_q + (coarse_q ? 6'd10 : 6'd1);
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	assign result.year            = year_q;
	assign result.year_of_century = yoc_q;
	assign result.month           = month_q + 4'd1;
	assign result.day_of_month    = day_q + 5'd1;
	assign result.hour            = hour_q;
	assign result.minute          = minute_q;
	assign result.second          = rem_q[SEC_W-1:0];

endmodule

// File: rtl/core/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unsigned 32-bit seconds since 1970-01-01 00:00:00 to calendar fields.
// ----------------------------------------------------------------------------
// usage:
//   stamp : valid/ready channel, one item is a 32-bit seconds count
//   cal   : valid/ready channel, one item is year, year of century, month,
//           day of month, hour, minute and second
// the block takes one item at a time; stamp.ready is high only while the
// sequencer is idle. one compare/subtract unit walks the seconds count down:
//   the years from 1970, then the months up to december, then days,
//   hours and minutes in steps of ten and then of one, and last the
//   hand over to the output register.
// once the result is handed over, the sequencer is idle again and the
// next item can be taken.
// the output register lets a new item be accepted while a result waits;
// if cal stalls, a finished item waits in the sequencer until the register frees.
// reset (arst_n low) empties the output register and idles the sequencer.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
	input  logic         clk,
	input  logic         arst_n,
	esc_stamp_if.sink    stamp,
	esc_cal_if.source    cal
);
	import esc_pkg::*;

	esc_stat_t   stat;
	esc_result_t result;
	esc_result_t res_q;
	logic        out_valid_q;
	logic        start;
	logic        take;

	assign stamp.ready = stat.idle;
	assign start       = stamp.valid & stat.idle;
	assign take        = stat.done & (~out_valid_q | cal.ready);

	esc_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.timestamp (stamp.timestamp),
		.take      (take),
		.stat      (stat),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (cal.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= result;
		end
	end

	assign cal.valid           = out_valid_q;
	assign cal.year            = res_q.year;
	assign cal.year_of_century = res_q.year_of_century;
	assign cal.month           = res_q.month;
	assign cal.day_of_month    = res_q.day_of_month;
	assign cal.hour            = res_q.hour;
	assign cal.minute          = res_q.minute;
	assign cal.second          = res_q.second;

endmodule

// File: rtl/core/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port level checks for the seconds to calendar block.
// ----------------------------------------------------------------------------
module esc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          stamp_valid,
	input logic                          stamp_ready,
	input logic                          cal_valid,
	input logic                          cal_ready,
	input logic [esc_pkg::YEAR_W-1:0]    year,
	input logic [esc_pkg::YOC_W-1:0]     year_of_century,
	input logic [esc_pkg::MONTH_W-1:0]   month,
	input logic [esc_pkg::DAY_W-1:0]     day_of_month,
	input logic [esc_pkg::HOUR_W-1:0]    hour
);
	import esc_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && !cal_ready |=> cal_valid)
		else $error("result dropped while stalled");

	// sequencer is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_valid && stamp_ready |=> !stamp_ready)
		else $error("ready after accepting an item");

	// an item taken while no result is offered cannot have its result offered too early
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_valid && stamp_ready && !cal_valid |=> ##1 !cal_valid)
		else $error("result too early");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0)
			&& (hour <= 5'd23))
		else $error("calendar field out of range");

	a_year: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (year >= 12'd1970) && (year <= 12'd2106) && (year_of_century <= 7'd99))
		else $error("year out of range");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.stamp_valid     (stamp.valid),
	.stamp_ready     (stamp.ready),
	.cal_valid       (cal.valid),
	.cal_ready       (cal.ready),
	.year            (cal.year),
	.year_of_century (cal.year_of_century),
	.month           (cal.month),
	.day_of_month    (cal.day_of_month),
	.hour            (cal.hour)
);

// File: tb/tb_calendar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_checker
// Watches both channels of the seconds to calendar block, works out the
// calendar date for every timestamp taken in and compares each result
// leaving the block with the oldest date still owed.
// ----------------------------------------------------------------------------
module tb_calendar_checker (
	input  logic        clk,
	input  logic        arst_n,
	esc_stamp_if        stamp,
	esc_cal_if          cal,
	output int          pending,
	output int          fail_count
);
	import esc_pkg::*;

	localparam int unsigned DAY_SECS    = 86400;
	localparam int unsigned HOUR_SECS   = 3600;
	localparam int unsigned MINUTE_SECS = 60;
	localparam int unsigned EPOCH_YEAR  = 1970;

	// common year month lengths, december at the top index
	localparam logic [11:0][4:0] MONTH_LEN = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
		5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

	esc_result_t expected_dates [$];
	int          failures = 0;
	int          owed     = 0;

	assign pending    = owed;
	assign fail_count = failures;

	function automatic logic leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic esc_result_t calendar_of(input logic [TS_W-1:0] secs);
		int unsigned day_count;
		int unsigned day_secs;
		int unsigned yr;
		int unsigned mon;
		int unsigned span;
		logic        leap;
		esc_result_t r;
		day_count = secs / DAY_SECS;
		day_secs  = secs % DAY_SECS;
		yr        = EPOCH_YEAR;
		span      = leap_year(yr) ? 366 : 365;
		while (day_count >= span) begin
			day_count -= span;
			yr++;
			span = leap_year(yr) ? 366 : 365;
		end
		leap = leap_year(yr);
		mon  = 0;
		span = MONTH_LEN[0];
		while (mon < 11 && day_count >= span) begin
			day_count -= span;
			mon++;
			span = MONTH_LEN[mon] + ((mon == 1 && leap) ? 1 : 0);
		end
		r.year            = YEAR_W'(yr);
		r.year_of_century = YOC_W'(yr % 100);
		r.month           = MONTH_W'(mon + 1);
		r.day_of_month    = DAY_W'(day_count + 1);
		r.hour            = HOUR_W'(day_secs / HOUR_SECS);
		r.minute          = MIN_W'((day_secs % HOUR_SECS) / MINUTE_SECS);
		r.second          = SEC_W'(day_secs % MINUTE_SECS);
		return r;
	endfunction

	function automatic void compare_field(input string field, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		esc_result_t want;
		if (arst_n) begin
			if (cal.valid && cal.ready) begin
				if (expected_dates.size() == 0) begin
					$error("calendar item with no timestamp waiting");
					failures++;
				end else begin
					want = expected_dates.pop_front();
					compare_field("year", 12'(want.year), 12'(cal.year));
					compare_field("year_of_century", 12'(want.year_of_century),
						12'(cal.year_of_century));
					compare_field("month", 12'(want.month), 12'(cal.month));
					compare_field("day_of_month", 12'(want.day_of_month), 12'(cal.day_of_month));
					compare_field("hour", 12'(want.hour), 12'(cal.hour));
					compare_field("minute", 12'(want.minute), 12'(cal.minute));
					compare_field("second", 12'(want.second), 12'(cal.second));
				end
			end
			if (stamp.valid && stamp.ready)
				expected_dates.push_back(calendar_of(stamp.timestamp));
			owed = expected_dates.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives timestamps into the seconds to calendar block with random gaps and
// result back-pressure: calendar corners first, then random timestamps
// weighted towards day boundaries and both ends of the range.
// ----------------------------------------------------------------------------
module tb_top;
	import esc_pkg::*;

	localparam int RANDOM_ITEMS  = 1630;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 200;
	localparam int IDLE_PERCENT  = 25;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   idle_cycles = 0;
	int   pending;
	int   fail_count;

	esc_stamp_if stamp_ch ();
	esc_cal_if   cal_ch ();

	epoch_seconds_to_calendar DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp_ch),
		.cal    (cal_ch)
	);

	tb_calendar_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.stamp      (stamp_ch),
		.cal        (cal_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cal_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// nothing accepted on either side for too long
	always @(posedge clk) begin
		if ((stamp_ch.valid && stamp_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("epoch_seconds_to_calendar: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_stamp(input logic [TS_W-1:0] secs);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				stamp_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		stamp_ch.valid     <= 1'b1;
		stamp_ch.timestamp <= secs;
		do @(posedge clk); while (!stamp_ch.ready);
	endtask

	// hold the input back until every owed date has come out
	task automatic drain_dates();
		stamp_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [TS_W-1:0] random_stamp();
		int unsigned pick;
		int unsigned day;
		logic [63:0] secs;
		pick = $urandom_range(0, 99);
		day  = $urandom_range(0, 49709);
		secs = 64'(day) * 64'd86400;
		if (pick < 55)
			return $urandom();
		else if (pick < 70)
			return TS_W'(secs);
		else if (pick < 80)
			return TS_W'(secs + 64'd86399);
		else if (pick < 90)
			return TS_W'($urandom_range(0, 86400 * 400));
		else
			return 32'hFFFF_FFFF - TS_W'($urandom_range(0, 86400 * 60));
	endfunction

	initial begin
		logic [TS_W-1:0] corner_stamps [$];
		corner_stamps = '{32'd0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd59, 32'd60,
			32'd3599, 32'd3600, 32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
			32'd68169600, 32'd68255999, 32'd946684799, 32'd946684800, 32'd951782400,
			32'd951868799, 32'd2147483647, 32'd2147483648, 32'd4102444800,
			32'd4107542399, 32'd4107542400, 32'd4291747199, 32'd4291747200};
		arst_n             = 1'b0;
		steady             = 1'b0;
		stamp_ch.valid     = 1'b0;
		stamp_ch.timestamp = '0;
		cal_ch.ready       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_stamps[i])
			send_stamp(corner_stamps[i]);
		drain_dates();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// a stretch with both sides running flat out
			steady <= (n >= 600 && n < 900);
			if (n == 1200)
				drain_dates();
			send_stamp(random_stamp());
		end
		drain_dates();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("epoch_seconds_to_calendar: match");
		else
			$display("epoch_seconds_to_calendar: mismatch");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/esc_sub_unit.sv
rtl/core/esc_calc.sv
rtl/core/epoch_seconds_to_calendar.sv
rtl/core/esc_checker.sv
tb/tb_calendar_checker.sv
tb/tb_top.sv
